@@ src/pidl_pkg.sv @@
// shared types, codes and defaults of the positional insert/delete list
// no dependencies
package pidl_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PLACE,
    S_DN,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  entry;
    logic [POS_W-1:0]   count;
    logic               last;
  } rsp_t;

endpackage

@@ src/pidl_if.sv @@
// request and response channel interfaces of the list
// depends on pidl_pkg
interface pidl_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [pidl_pkg::POS_W-1:0]  position;
  logic [pidl_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output position, output value, input ready);
  modport sink   (input valid, input req_type, input position, input value, output ready);
endinterface

interface pidl_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [pidl_pkg::DATA_W-1:0] entry;
  logic [pidl_pkg::POS_W-1:0]  count;
  logic                        last;

  modport source (output valid, output status, output entry, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input entry, input count, input last,
                  output ready);
endinterface

@@ src/positional_insert_delete_list_top.sv @@
// Ordered list of up to DEPTH signed 32-bit entries held in a single-port-write, single-port-read
// synchronous memory. One request is handled at a time. A refused request, a dump of an empty
// list, an insert at the tail and a delete of the last entry go from acceptance straight to the
// response state. An insert at position p moves the entries from the tail down to p up by one and
// then places the value at p; a delete at p moves the entries after p down by one. The memory moves
// one entry per cycle through its one write port. A dump gives one response per cycle after the
// registered read of the first entry, and stalls with the response channel. Responses wait in an
// output register; the next request is taken once the sequencer is back to idle. The list is
// empty after reset, with no clearing pass.
module positional_insert_delete_list_top #(
  parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pidl_in_if.sink     in_req,
  pidl_out_if.source  out_rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [pidl_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [pidl_pkg::DATA_W-1:0] mem_rdata;

  pidl_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pidl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ src/pidl_mem.sv @@
// entry store: one write port, one read port with registered read data
// depends on pidl_pkg
module pidl_mem #(
  parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pidl_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pidl_pkg::DATA_W-1:0] rdata
);

  logic [pidl_pkg::DATA_W-1:0] mem [DEPTH];
  logic [pidl_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pidl_ctrl.sv @@
// request sequencer: checks, shift sweeps through the store, dump and response register
// depends on pidl_pkg and pidl_if
module pidl_ctrl #(
  parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pidl_in_if.sink                     in_req,
  pidl_out_if.source                  out_rsp,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [pidl_pkg::DATA_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [pidl_pkg::DATA_W-1:0] mem_rdata
);

  localparam int unsigned CMPW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

  pidl_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [pidl_pkg::DATA_W-1:0] val_r, val_nxt;
  pidl_pkg::status_t           status_r, status_nxt;
  logic                        out_valid_r;
  pidl_pkg::rsp_t              out_data_r;

  logic                        acc;
  logic                        slot_free;
  logic                        push;
  pidl_pkg::rsp_t              push_data;
  pidl_pkg::req_t              req;
  logic [CMPW-1:0]             pos_c, cnt_c;
  logic                        ins_full, ins_bad, ins_tail;
  logic                        del_empty, del_bad, del_tail;
  logic                        up_done, dn_done, dump_last;

  assign in_req.ready = (state_r == pidl_pkg::S_IDLE);
  assign acc          = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;
  assign req          = pidl_pkg::req_t'(in_req.req_type);

  assign pos_c     = CMPW'(in_req.position);
  assign cnt_c     = CMPW'(cnt_r);
  assign ins_full  = (cnt_r == CW'(DEPTH));
  assign ins_bad   = (pos_c > cnt_c);
  assign ins_tail  = (pos_c == cnt_c);
  assign del_empty = (cnt_r == '0);
  assign del_bad   = (pos_c >= cnt_c);
  assign del_tail  = ((pos_c + 1'b1) == cnt_c);
  assign up_done   = (idx_r == AW'(pos_r + 1'b1));
  assign dn_done   = ((CW'(idx_r) + CW'(2)) == cnt_r);
  assign dump_last = ((CW'(idx_r) + CW'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        if (acc) begin
          unique case (req)
            pidl_pkg::REQ_INSERT: begin
              state_nxt = (ins_full || ins_bad || ins_tail) ? pidl_pkg::S_RESP : pidl_pkg::S_UP;
            end
            pidl_pkg::REQ_DELETE: begin
              state_nxt = (del_empty || del_bad || del_tail) ? pidl_pkg::S_RESP : pidl_pkg::S_DN;
            end
            pidl_pkg::REQ_DUMP: begin
              state_nxt = del_empty ? pidl_pkg::S_RESP : pidl_pkg::S_DUMP;
            end
            default: state_nxt = pidl_pkg::S_IDLE;
          endcase
        end
      end
      pidl_pkg::S_UP: begin
        if (up_done) state_nxt = pidl_pkg::S_PLACE;
      end
      pidl_pkg::S_PLACE: state_nxt = pidl_pkg::S_RESP;
      pidl_pkg::S_DN: begin
        if (dn_done) state_nxt = pidl_pkg::S_RESP;
      end
      pidl_pkg::S_DUMP: begin
        if (slot_free && dump_last) state_nxt = pidl_pkg::S_IDLE;
      end
      pidl_pkg::S_RESP: begin
        if (slot_free) state_nxt = pidl_pkg::S_IDLE;
      end
      default: state_nxt = pidl_pkg::S_IDLE;
    endcase
  end

  // store accesses, counters and responses
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    push       = 1'b0;
    push_data  = '{status: pidl_pkg::ST_OK, entry: '0,
                   count: pidl_pkg::POS_W'(cnt_r), last: 1'b1};
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        if (acc) begin
          pos_nxt = AW'(in_req.position);
          val_nxt = in_req.value;
          unique case (req)
            pidl_pkg::REQ_INSERT: begin
              status_nxt = pidl_pkg::ST_OK;
              if (ins_full) begin
                status_nxt = pidl_pkg::ST_FULL;
              end else if (ins_bad) begin
                status_nxt = pidl_pkg::ST_BADPOS;
              end else if (ins_tail) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_req.position);
                mem_wdata = in_req.value;
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                idx_nxt   = AW'(cnt_r);
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_r - 1'b1);
              end
            end
            pidl_pkg::REQ_DELETE: begin
              status_nxt = pidl_pkg::ST_OK;
              if (del_empty) begin
                status_nxt = pidl_pkg::ST_EMPTY;
              end else if (del_bad) begin
                status_nxt = pidl_pkg::ST_BADPOS;
              end else if (del_tail) begin
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                idx_nxt   = AW'(in_req.position);
                mem_re    = 1'b1;
                mem_raddr = AW'(in_req.position) + 1'b1;
              end
            end
            pidl_pkg::REQ_DUMP: begin
              status_nxt = pidl_pkg::ST_EMPTY;
              if (!del_empty) begin
                status_nxt = pidl_pkg::ST_OK;
                idx_nxt    = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
              end
            end
            default: status_nxt = status_r;
          endcase
        end
      end
      pidl_pkg::S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (!up_done) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - 1'b1 - 1'b1;
          idx_nxt   = idx_r - 1'b1;
        end
      end
      pidl_pkg::S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + 1'b1;
      end
      pidl_pkg::S_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (dn_done) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + 1'b1 + 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      pidl_pkg::S_DUMP: begin
        if (slot_free) begin
          push      = 1'b1;
          push_data = '{status: pidl_pkg::ST_OK, entry: mem_rdata,
                        count: pidl_pkg::POS_W'(cnt_r), last: dump_last};
          if (!dump_last) begin
            mem_re    = 1'b1;
            mem_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      pidl_pkg::S_RESP: begin
        if (slot_free) begin
          push      = 1'b1;
          push_data = '{status: status_r, entry: '0,
                        count: pidl_pkg::POS_W'(cnt_r), last: 1'b1};
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidl_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_data_r.status;
  assign out_rsp.entry  = out_data_r.entry;
  assign out_rsp.count  = out_data_r.count;
  assign out_rsp.last   = out_data_r.last;

endmodule

@@ src/pidl_chk.sv @@
// port-level checks of the list's response channel, bound to the top level
// depends on pidl_pkg and positional_insert_delete_list_top
module pidl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [pidl_pkg::DATA_W-1:0] out_entry,
  input logic [pidl_pkg::POS_W-1:0]  out_count,
  input logic                        out_last
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_entry)
      && $stable(out_count) && $stable(out_last))
    else $error("response changed while stalled");

  a_refused_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pidl_pkg::ST_OK) |-> out_last && (out_entry == '0))
    else $error("refused request gave more than one response or an entry");

  a_dump_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && (out_count == $past(out_count)))
    else $error("dump stream broken or count changed during dump");

endmodule

bind positional_insert_delete_list_top pidl_chk u_pidl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_entry  (out_rsp.entry),
  .out_count  (out_rsp.count),
  .out_last   (out_rsp.last)
);
